FILE: hdl/array_list_engine_defines.svh
// ---------------------------------------------------------------------------
// Array list engine assertion macros
// Shared property wrappers for the concurrent checks of the engine.
// ---------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_DEFINES_SVH
`define ARRAY_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ALE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ALE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ale_pkg.sv
// ---------------------------------------------------------------------------
// ale_pkg
// Command, status and sequencer state types of the array list engine.
// ---------------------------------------------------------------------------
package ale_pkg;

  // Command codes carried by a request.
  typedef enum logic [2:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_LOCATE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_INS,
    S_FIN
  } state_t;

endpackage

FILE: hdl/ale_req_if.sv
// ---------------------------------------------------------------------------
// ale_req_if
// Request channel of the array list engine: valid/ready with the command.
// ---------------------------------------------------------------------------
interface ale_req_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  cmd;
  logic        [6:0]  position;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output position, output value, input ready);
  modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

FILE: hdl/ale_rsp_if.sv
// ---------------------------------------------------------------------------
// ale_rsp_if
// Result channel of the array list engine: valid/ready with the result.
// ---------------------------------------------------------------------------
interface ale_rsp_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  status;
  logic signed [31:0] data_out;
  logic        [5:0]  found_index;
  logic        [6:0]  count;
  logic               is_empty;

  modport source (output valid, output status, output data_out, output found_index,
                  output count, output is_empty, input ready);
  modport sink   (input valid, input status, input data_out, input found_index,
                  input count, input is_empty, output ready);
endinterface

FILE: hdl/array_list_engine.sv
// ---------------------------------------------------------------------------
// array_list_engine
// Array list of signed 32-bit values held in one synchronous memory, with
// insert, delete, get, locate and clear commands and one result each.
// ---------------------------------------------------------------------------
// Channel  Dir  Payload                                       Accepted when
// req      in   cmd, position, value                          valid && ready
// rsp      out  status, data_out, found_index, count, is_empty valid && ready
//
// One request is processed at a time; ready is high in the idle state.
// Insert shifts the entries from its position upward, delete shifts those
// above its position down, get reads one entry, locate scans from the start
// and clear zeroes the entries of the list; a rejected request goes straight
// to its result. The memory has one read and one write port, so the list is
// walked entry by entry. Reset clears control and length; the memory is not
// cleared.
// A stalled result waits in the output register while the next request is
// accepted and processed up to its own result.
// ---------------------------------------------------------------------------
`include "array_list_engine_defines.svh"

module array_list_engine
  import ale_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst,
  ale_req_if.sink   req,
  ale_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);
  localparam int CW = (LW > 7) ? LW : 7;
  localparam int FW = (AW > 6) ? AW : 6;

  // Entry storage.
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  // Control and working registers.
  state_t        state;
  state_t        state_next;
  cmd_t          op;
  logic [LW-1:0] len;
  logic [LW-1:0] pos_r;
  logic [31:0]   val_r;
  logic [LW-1:0] r;
  logic [LW-1:0] lim;
  logic          rv;
  logic [AW-1:0] ra;
  status_t       res_status;
  logic [31:0]   res_data;
  logic [AW-1:0] res_fidx;

  // Output register.
  logic          out_valid;
  status_t       out_status;
  logic [31:0]   out_data;
  logic [5:0]    out_fidx;
  logic [6:0]    out_count;
  logic          out_empty;

  // Derived signals.
  logic          accept;
  logic          out_free;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic [FW-1:0] fidx_ext;
  logic          pos_in_list;
  logic          pos_le_len;
  logic          is_full;
  logic          hit;
  logic          walk_done;
  logic          ins_done;
  logic [LW-1:0] r_dec;
  logic [LW-1:0] pos_inc;

  assign accept      = req.valid && req.ready;
  assign out_free    = !out_valid || rsp.ready;
  assign pos_ext     = CW'(req.position);
  assign len_ext     = CW'(len);
  assign fidx_ext    = FW'(res_fidx);
  assign pos_in_list = pos_ext < len_ext;
  assign pos_le_len  = pos_ext <= len_ext;
  assign is_full     = len == LW'(DEPTH);
  assign r_dec       = r - LW'(1);
  assign pos_inc     = pos_ext[LW-1:0] + LW'(1);
  assign hit         = rv && (op == CMD_LOCATE) && (rdata == val_r);
  assign walk_done   = hit || ((r == lim) && !rv);
  assign ins_done    = (r == pos_r) && !rv;

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  // Memory access control for the walking states.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state)
      S_WALK: begin
        if (op == CMD_CLEAR) begin
          // Clear writes zero into one entry per cycle.
          if (r != lim) begin
            mem_we    = 1'b1;
            mem_waddr = r[AW-1:0];
          end
        end else begin
          // Scan reads ahead; delete writes each entry one place down.
          if ((r != lim) && !hit) begin
            mem_re    = 1'b1;
            mem_raddr = r[AW-1:0];
          end
          if (rv && (op == CMD_DELETE) && (ra != pos_r[AW-1:0])) begin
            mem_we    = 1'b1;
            mem_waddr = ra - AW'(1);
            mem_wdata = rdata;
          end
        end
      end
      S_INS: begin
        // Shift from the top down, then drop the new value into place.
        if (rv) begin
          mem_we    = 1'b1;
          mem_waddr = ra;
          mem_wdata = rdata;
        end else if (r == pos_r) begin
          mem_we    = 1'b1;
          mem_waddr = pos_r[AW-1:0];
          mem_wdata = val_r;
        end
        if (r != pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_INSERT:  state_next = (pos_le_len && !is_full) ? S_INS : S_FIN;
            CMD_DELETE,
            CMD_GET:     state_next = pos_in_list ? S_WALK : S_FIN;
            CMD_LOCATE,
            CMD_CLEAR:   state_next = S_WALK;
            default:     state_next = S_FIN;
          endcase
        end
      end
      S_WALK: begin
        if (walk_done) begin
          state_next = S_FIN;
        end
      end
      S_INS: begin
        if (ins_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Length, walk pointers and result collection.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      rv  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= cmd_t'(req.cmd);
            val_r    <= req.value;
            pos_r    <= pos_ext[LW-1:0];
            rv       <= 1'b0;
            res_data <= '0;
            res_fidx <= '0;
            case (req.cmd)
              CMD_INSERT: begin
                r   <= len;
                lim <= len;
                if (!pos_le_len) begin
                  res_status <= ST_RANGE;
                end else if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_OK;
                end
              end
              CMD_DELETE: begin
                r          <= pos_ext[LW-1:0];
                lim        <= len;
                res_status <= pos_in_list ? ST_OK : ST_RANGE;
              end
              CMD_GET: begin
                r          <= pos_ext[LW-1:0];
                lim        <= pos_inc;
                res_status <= pos_in_list ? ST_OK : ST_RANGE;
              end
              CMD_LOCATE: begin
                r          <= '0;
                lim        <= len;
                res_status <= ST_NOTFOUND;
              end
              default: begin
                r          <= '0;
                lim        <= len;
                res_status <= ST_OK;
              end
            endcase
          end
        end
        S_WALK: begin
          rv <= mem_re;
          if (mem_re) begin
            ra <= mem_raddr;
          end
          if (mem_re || (op == CMD_CLEAR && mem_we)) begin
            r <= r + LW'(1);
          end
          // The first read of a delete or get is the entry returned.
          if (rv && ((op == CMD_DELETE) || (op == CMD_GET)) &&
              (ra == pos_r[AW-1:0])) begin
            res_data <= rdata;
          end
          if (hit) begin
            res_status <= ST_OK;
            res_fidx   <= ra;
          end
          if (walk_done && (op == CMD_DELETE)) begin
            len <= len - LW'(1);
          end
        end
        S_INS: begin
          rv <= mem_re;
          if (mem_re) begin
            ra <= r[AW-1:0];
            r  <= r_dec;
          end
          if (ins_done) begin
            len <= len + LW'(1);
          end
        end
        default: begin
          rv <= 1'b0;
        end
      endcase
    end
  end

  // Output register: loaded from the finish state once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid  <= 1'b1;
      out_status <= res_status;
      out_data   <= res_data;
      out_fidx   <= fidx_ext[5:0];
      out_count  <= len_ext[6:0];
      out_empty  <= (len == '0);
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.data_out    = out_data;
  assign rsp.found_index = out_fidx;
  assign rsp.count       = out_count;
  assign rsp.is_empty    = out_empty;

  // Checks on the sequencer and the memory port use.
  `ALE_ASSERT_IMP(a_len_bound, clk, rst, 1'b1, len <= LW'(DEPTH), "length exceeds depth")
  `ALE_ASSERT_IMP(a_no_rw_clash, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit one entry")
  `ALE_ASSERT_NXT(a_busy_after_req, clk, rst, accept, !req.ready, "second request taken while busy")
  `ALE_ASSERT_IMP(a_empty_flag, clk, rst, rsp.valid, rsp.is_empty == (rsp.count == 7'd0), "empty flag disagrees with count")

endmodule
